>>> rtl/gbba_pkg.sv
`default_nettype none
// ============================================================================
// gbba_pkg
// Shared types, codes and constants of the group-by bar aggregator.
// ============================================================================
package gbba_pkg;

	localparam int TableDepth = 256;
	localparam int IdxW       = 8;
	localparam int CntW       = 9;
	localparam int MaxColumns = 4;
	localparam int ColW       = 2;
	localparam int QDepth     = 2;

	// Status codes
	localparam logic [2:0] ST_UPDATED = 3'd0;
	localparam logic [2:0] ST_CREATED = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_READ_OK = 3'd3;
	localparam logic [2:0] ST_READ_NO = 3'd4;

	// Column modes
	localparam logic [2:0] MODE_SUM   = 3'd0;
	localparam logic [2:0] MODE_COUNT = 3'd1;
	localparam logic [2:0] MODE_MIN   = 3'd2;
	localparam logic [2:0] MODE_MAX   = 3'd3;
	localparam logic [2:0] MODE_FIRST = 3'd4;
	localparam logic [2:0] MODE_LAST  = 3'd5;

	// Column sources
	localparam logic [1:0] SRC_PRICE  = 2'd1;
	localparam logic [1:0] SRC_VOLUME = 2'd2;

	// Register addresses (byte address / 8)
	localparam logic [1:0] REG_BAR_WIDTH = 2'd0;
	localparam logic [1:0] REG_COL_COUNT = 2'd1;
	localparam logic [1:0] REG_COL_MODES = 2'd2;
	localparam logic [1:0] REG_COL_SRCS  = 2'd3;

	localparam logic [63:0] SIGNED_TOP    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SIGNED_BOTTOM = 64'h8000_0000_0000_0000;

	// Classified item handed from the front end to the back end
	typedef struct packed {
		logic        action;
		logic [31:0] symbol;
		logic [63:0] bar;
		logic [63:0] price;
		logic [63:0] volume;
		logic [7:0]  read_index;
	} job_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  entry_index;
		logic [31:0] group_symbol;
		logic [63:0] bar_start;
		logic [63:0] value_zero;
		logic [63:0] value_one;
		logic [63:0] value_two;
		logic [63:0] value_three;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/gbba_ram.sv
`default_nettype none
// ============================================================================
// gbba_ram
// Generic single-port RAM with registered read.
// ============================================================================
module gbba_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(Depth)-1:0] addr,
	input  wire [Width-1:0]         wdata,
	output logic [Width-1:0]        rdata
);
	logic [Width-1:0] mem [Depth];

	// Write or read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> rtl/gbba_front.sv
`default_nettype none
// ============================================================================
// gbba_front
// Accepts items and computes the bar start with a restoring divider.
// ============================================================================
module gbba_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  in_action,
	input  wire  [31:0]          in_symbol,
	input  wire  [63:0]          in_timestamp,
	input  wire  [63:0]          in_price,
	input  wire  [63:0]          in_volume,
	input  wire  [7:0]           in_read_index,
	input  wire  [62:0]          bar_width,
	output logic                 job_valid,
	input  wire                  job_ready,
	output gbba_pkg::job_t       job
);
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_MUL  = 2'd2;
	localparam logic [1:0] F_OUT  = 2'd3;

	logic [1:0]     state_q;
	gbba_pkg::job_t job_q;
	logic [63:0]    quo_q;
	logic [63:0]    rem_q;
	logic [6:0]     step_q;
	logic           neg_q;
	logic [5:0]     mstep_q;
	logic [63:0]    prod_q;
	logic [63:0]    mq_q;
	logic [63:0]    abs_ts;
	logic [64:0]    trial;
	logic [63:0]    width64;

	assign width64  = {1'b0, bar_width};
	assign abs_ts   = in_timestamp[63] ? (~in_timestamp + 64'd1) : in_timestamp;
	assign trial    = {rem_q, quo_q[63]} - {1'b0, width64};
	assign in_ready = (state_q == F_IDLE);
	// Hold the transaction back while the bar start lands
	assign job_valid = (state_q == F_OUT) && (mstep_q != 6'd33);
	assign job      = job_q;

	// Sequence: divide one bit a cycle, multiply back one bit pair a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			mstep_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						job_q.action     <= in_action;
						job_q.symbol     <= in_symbol;
						job_q.price      <= in_price;
						job_q.volume     <= in_volume;
						job_q.read_index <= in_read_index;
						job_q.bar        <= '0;
						quo_q  <= abs_ts;
						rem_q  <= '0;
						neg_q  <= in_timestamp[63];
						step_q <= '0;
						if (in_action || bar_width == '0) begin
							state_q <= F_OUT;
						end else begin
							state_q <= F_DIV;
						end
					end
				end
				F_DIV: begin
					if (!trial[64]) begin
						rem_q <= trial[63:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], quo_q[63]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
					step_q <= step_q + 7'd1;
					if (step_q == 7'd63) begin
						state_q <= F_MUL;
						mstep_q <= '0;
						prod_q  <= '0;
					end
				end
				F_MUL: begin
					// Shift-add: quotient times width, MSB first, two bits a cycle
					if (mstep_q == 6'd0) begin
						mq_q    <= quo_q;
						prod_q  <= '0;
						mstep_q <= 6'd1;
					end else begin
						prod_q <= (prod_q << 2)
							+ (mq_q[63] ? (width64 << 1) : 64'd0)
							+ (mq_q[62] ? width64 : 64'd0);
						mq_q   <= mq_q << 2;
						mstep_q <= mstep_q + 6'd1;
						if (mstep_q == 6'd32) begin
							state_q <= F_OUT;
						end
					end
				end
				F_OUT: begin
					if (mstep_q == 6'd33) begin
						job_q.bar <= neg_q ? (~prod_q + 64'd1) : prod_q;
						mstep_q   <= '0;
					end else if (job_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/gbba_queue.sv
`default_nettype none
// ============================================================================
// gbba_queue
// Short FIFO between front end and back end.
// ============================================================================
module gbba_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_valid,
	output logic                wr_ready,
	input  gbba_pkg::job_t      wr_data,
	output logic                rd_valid,
	input  wire                 rd_ready,
	output gbba_pkg::job_t      rd_data
);
	gbba_pkg::job_t slot_q [gbba_pkg::QDepth];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = slot_q[rp_q];

	// Advance pointers on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_valid && wr_ready) begin
				wp_q <= ~wp_q;
			end
			if (rd_valid && rd_ready) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) begin
			slot_q[wp_q] <= wr_data;
		end
	end
endmodule
`default_nettype wire

>>> rtl/gbba_back.sv
`default_nettype none
// ============================================================================
// gbba_back
// Searches the bucket table, allocates, folds columns and forms results.
// ============================================================================
module gbba_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  job_valid,
	output logic                 job_ready,
	input  gbba_pkg::job_t       job,
	input  wire  [2:0]           column_count,
	input  wire  [11:0]          column_modes,
	input  wire  [7:0]           column_sources,
	output logic                 res_valid,
	input  wire                  res_ready,
	output gbba_pkg::result_t    res
);
	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_SRCH  = 4'd1;
	localparam logic [3:0] B_CMP   = 4'd2;
	localparam logic [3:0] B_DEC   = 4'd3;
	localparam logic [3:0] B_VRD   = 4'd4;
	localparam logic [3:0] B_VWAIT = 4'd5;
	localparam logic [3:0] B_VUPD  = 4'd6;
	localparam logic [3:0] B_OUT   = 4'd7;

	logic [3:0]        state_q;
	logic [gbba_pkg::TableDepth-1:0] used_q;
	logic [gbba_pkg::CntW-1:0] count_q;
	logic [gbba_pkg::IdxW-1:0] sidx_q;
	logic [gbba_pkg::IdxW-1:0] idx_q;
	logic [gbba_pkg::ColW-1:0] col_q;
	logic              found_q;
	logic              created_q;
	gbba_pkg::job_t    job_q;
	gbba_pkg::result_t res_q;
	logic [63:0]       vals_q [gbba_pkg::MaxColumns];

	logic              k_we;
	logic [gbba_pkg::IdxW-1:0] k_addr;
	logic [95:0]       k_rdata;
	logic              v_we;
	logic [gbba_pkg::IdxW+gbba_pkg::ColW-1:0] v_addr;
	logic [63:0]       v_wdata;
	logic [63:0]       v_rdata;
	logic [2:0]        ncol;
	logic [2:0]        mode_c;
	logic [1:0]        srcsel_c;
	logic [63:0]       src_c;
	logic [63:0]       cur_c;
	logic [63:0]       new_c;

	// Key store: symbol and bar per entry
	gbba_ram #(.Width(96), .Depth(gbba_pkg::TableDepth)) u_keys (
		.clk(clk), .we(k_we), .addr(k_addr),
		.wdata({job_q.symbol, job_q.bar}), .rdata(k_rdata)
	);

	// Value store: one word per entry and column
	gbba_ram #(.Width(64), .Depth(gbba_pkg::TableDepth * gbba_pkg::MaxColumns)) u_vals (
		.clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
	);

	assign ncol      = (column_count > 3'd4) ? 3'd4 : column_count;
	assign job_ready = (state_q == B_IDLE);
	assign res_valid = (state_q == B_OUT);
	assign res       = res_q;
	assign k_we      = (state_q == B_DEC) && !found_q
		&& !job_q.action && !count_q[gbba_pkg::IdxW];
	assign k_addr    = (state_q == B_DEC) ? count_q[gbba_pkg::IdxW-1:0]
		: (state_q == B_IDLE ? job.read_index : sidx_q);
	assign v_addr    = {idx_q, col_q};

	assign mode_c   = column_modes[3*col_q +: 3];
	assign srcsel_c = column_sources[2*col_q +: 2];
	assign src_c    = (srcsel_c == gbba_pkg::SRC_PRICE) ? job_q.price
		: (srcsel_c == gbba_pkg::SRC_VOLUME) ? job_q.volume : 64'd0;

	// Start value for a new entry, else the stored word
	always_comb begin
		if (created_q) begin
			unique case (mode_c)
				gbba_pkg::MODE_MIN: cur_c = gbba_pkg::SIGNED_TOP;
				gbba_pkg::MODE_MAX: cur_c = gbba_pkg::SIGNED_BOTTOM;
				default:            cur_c = 64'd0;
			endcase
		end else begin
			cur_c = v_rdata;
		end
	end

	// Fold one column
	always_comb begin
		new_c = cur_c;
		if (!job_q.action && {1'b0, col_q} < ncol) begin
			unique case (mode_c)
				gbba_pkg::MODE_SUM:   new_c = cur_c + src_c;
				gbba_pkg::MODE_COUNT: new_c = cur_c + 64'd1;
				gbba_pkg::MODE_MIN:   if ($signed(src_c) < $signed(cur_c)) new_c = src_c;
				gbba_pkg::MODE_MAX:   if ($signed(cur_c) < $signed(src_c)) new_c = src_c;
				gbba_pkg::MODE_FIRST: if (created_q) new_c = src_c;
				gbba_pkg::MODE_LAST:  new_c = src_c;
				default:              new_c = cur_c;
			endcase
		end
	end

	assign v_we    = (state_q == B_VUPD) && !job_q.action;
	assign v_wdata = new_c;

	// Sequence the search, allocation and column pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			used_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						created_q <= 1'b0;
						col_q   <= '0;
						if (job.action) begin
							sidx_q  <= job.read_index;
							idx_q   <= job.read_index;
							found_q <= used_q[job.read_index];
							state_q <= B_VRD;
						end else begin
							sidx_q  <= '0;
							found_q <= 1'b0;
							state_q <= B_SRCH;
						end
					end
				end
				B_SRCH: state_q <= B_CMP;
				B_CMP: begin
					if (used_q[sidx_q] && k_rdata == {job_q.symbol, job_q.bar}) begin
						found_q <= 1'b1;
						idx_q   <= sidx_q;
						state_q <= B_DEC;
					end else if (sidx_q == gbba_pkg::IdxW'(gbba_pkg::TableDepth - 1)
						|| !used_q[sidx_q]) begin
						state_q <= B_DEC;
					end else begin
						sidx_q  <= sidx_q + 1'b1;
						state_q <= B_SRCH;
					end
				end
				B_DEC: begin
					if (found_q) begin
						state_q <= B_VRD;
					end else if (count_q[gbba_pkg::IdxW]) begin
						res_q.status       <= gbba_pkg::ST_FULL;
						res_q.entry_index  <= '0;
						res_q.group_symbol <= job_q.symbol;
						res_q.bar_start    <= job_q.bar;
						res_q.value_zero   <= '0;
						res_q.value_one    <= '0;
						res_q.value_two    <= '0;
						res_q.value_three  <= '0;
						state_q <= B_OUT;
					end else begin
						idx_q     <= count_q[gbba_pkg::IdxW-1:0];
						used_q[count_q[gbba_pkg::IdxW-1:0]] <= 1'b1;
						count_q   <= count_q + 1'b1;
						created_q <= 1'b1;
						state_q   <= B_VRD;
					end
				end
				B_VRD: state_q <= B_VWAIT;
				B_VWAIT: state_q <= B_VUPD;
				B_VUPD: begin
					vals_q[col_q] <= new_c;
					col_q <= col_q + 1'b1;
					if (col_q == gbba_pkg::ColW'(gbba_pkg::MaxColumns - 1)) begin
						state_q <= B_OUT;
						res_q.entry_index <= idx_q;
						if (job_q.action) begin
							res_q.status <= found_q ? gbba_pkg::ST_READ_OK
								: gbba_pkg::ST_READ_NO;
							res_q.group_symbol <= found_q ? k_rdata[95:64] : 32'd0;
							res_q.bar_start    <= found_q ? k_rdata[63:0] : 64'd0;
						end else begin
							res_q.status <= created_q ? gbba_pkg::ST_CREATED
								: gbba_pkg::ST_UPDATED;
							res_q.group_symbol <= job_q.symbol;
							res_q.bar_start    <= job_q.bar;
						end
						// Place column values, masking disabled columns and empty reads
						res_q.value_zero  <= (ncol > 3'd0 && (found_q || !job_q.action))
							? vals_q[0] : 64'd0;
						res_q.value_one   <= (ncol > 3'd1 && (found_q || !job_q.action))
							? vals_q[1] : 64'd0;
						res_q.value_two   <= (ncol > 3'd2 && (found_q || !job_q.action))
							? vals_q[2] : 64'd0;
						res_q.value_three <= (ncol > 3'd3 && (found_q || !job_q.action))
							? new_c : 64'd0;
					end else begin
						state_q <= B_VRD;
					end
				end
				B_OUT: begin
					if (res_ready) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Table never holds more entries than it has
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= gbba_pkg::CntW'(gbba_pkg::TableDepth))
		else $error("fill count overflow");
	// A full table always reports a drop
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DEC && !found_q && count_q[gbba_pkg::IdxW] && !job_q.action)
		|=> res_q.status == gbba_pkg::ST_FULL)
		else $error("full table not dropped");
	// Allocation grows the fill count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		k_we |=> count_q == $past(count_q) + 1'b1)
		else $error("allocation count slip");
endmodule
`default_nettype wire

>>> rtl/group_by_bar_aggregator_unit.sv
`default_nettype none
// ============================================================================
// group_by_bar_aggregator_unit
// Groups trade ticks by symbol and time bar and keeps per-bucket aggregates.
// ============================================================================
//  channel | dir | transaction
//  s_axis  | in  | one tick or read request
//  m_axis  | out | one status and entry result
//  apb     | in  | register write / read
// A tick passes from acceptance to result through the divide, the multiply
// back, landing the bar start, the queue, a search and compare per table
// entry for k entries (1 to 256), the decide state and the four column
// read-modify-writes. A zero bar width skips the divide and multiply, a dropped
// tick skips the column pass; a read skips divide, multiply, search and decide.
// Reset clears the used bits and fill count at once; no clearing pass.
// The queue lets the divider start on the next tick while the table
// works or the result waits.
module group_by_bar_aggregator_unit (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// symbol, timestamp, price, volume, read_index (lowest first), pad to 240
	input  wire  [239:0] s_axis_tdata,
	// action
	input  wire  [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// entry_index, group_symbol, bar_start, value_zero..value_three
	output logic [359:0] m_axis_tdata,
	// status
	output logic [2:0]   m_axis_tuser,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [4:0]   paddr,
	input  wire  [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);
	logic [62:0] bar_width_q;
	logic [2:0]  column_count_q;
	logic [11:0] column_modes_q;
	logic [7:0]  column_sources_q;
	logic        fj_valid;
	logic        fj_ready;
	gbba_pkg::job_t fj;
	logic        bj_valid;
	logic        bj_ready;
	gbba_pkg::job_t bj;
	gbba_pkg::result_t res;

	assign pready = 1'b1;

	// Write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_width_q      <= '0;
			column_count_q   <= '0;
			column_modes_q   <= '0;
			column_sources_q <= '0;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			unique case (paddr[4:3])
				gbba_pkg::REG_BAR_WIDTH: bar_width_q      <= pwdata[62:0];
				gbba_pkg::REG_COL_COUNT: column_count_q   <= pwdata[2:0];
				gbba_pkg::REG_COL_MODES: column_modes_q   <= pwdata[11:0];
				gbba_pkg::REG_COL_SRCS:  column_sources_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read registers
	always_comb begin
		unique case (paddr[4:3])
			gbba_pkg::REG_BAR_WIDTH: prdata = {1'b0, bar_width_q};
			gbba_pkg::REG_COL_COUNT: prdata = {61'd0, column_count_q};
			gbba_pkg::REG_COL_MODES: prdata = {52'd0, column_modes_q};
			default:                 prdata = {56'd0, column_sources_q};
		endcase
	end

	gbba_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_action(s_axis_tuser[0]),
		.in_symbol(s_axis_tdata[31:0]),
		.in_timestamp(s_axis_tdata[95:32]),
		.in_price(s_axis_tdata[159:96]),
		.in_volume(s_axis_tdata[223:160]),
		.in_read_index(s_axis_tdata[231:224]),
		.bar_width(bar_width_q),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	gbba_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
	);

	gbba_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.column_count(column_count_q), .column_modes(column_modes_q),
		.column_sources(column_sources_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {res.value_three, res.value_two, res.value_one,
		res.value_zero, res.bar_start, res.group_symbol, res.entry_index};
endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Group-by bar aggregator testbench
// Drives ticks and entry reads through the stream port and sets the registers
// over APB. An in-bench model of the bucket table predicts each result. The
// run starts with a short directed table, then moves through several register
// settings with random traffic and random idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
	import gbba_pkg::*;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_READ = 1'b1;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;
	localparam logic [1:0] SRC_ZERO  = 2'd0;
	localparam logic [1:0] SRC_SPARE = 2'd3;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 256;
	localparam int CYCLE_LIMIT = 8000000;

	typedef struct {
		logic        action;
		logic [31:0] symbol;
		logic [63:0] stamp;
		logic [63:0] price;
		logic [63:0] volume;
		logic [7:0]  read_index;
	} tick_t;

	typedef struct {
		tick_t      item;
		bit         typed;
		logic [2:0] status;
		logic [7:0] index;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [239:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [359:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	group_by_bar_aggregator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bucket table shadow and register copies
	logic        bucket_used [TableDepth];
	logic [31:0] bucket_symbol [TableDepth];
	logic [63:0] bucket_bar [TableDepth];
	logic [63:0] bucket_value [TableDepth][MaxColumns];
	int          bucket_fill = 0;
	logic [62:0] width_reg = '0;
	logic [2:0]  count_reg = '0;
	logic [11:0] modes_reg = '0;
	logic [7:0]  sources_reg = '0;

	result_t pending_results[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	longint cycles = 0;

	function automatic logic [11:0] pack_modes(logic [2:0] m0, logic [2:0] m1,
			logic [2:0] m2, logic [2:0] m3);
		return {m3, m2, m1, m0};
	endfunction

	function automatic logic [7:0] pack_sources(logic [1:0] s0, logic [1:0] s1,
			logic [1:0] s2, logic [1:0] s3);
		return {s3, s2, s1, s0};
	endfunction

	// Fold one transaction into the table shadow and return its result
	function automatic result_t fold_tick(tick_t t);
		result_t r;
		int n;
		int idx;
		bit found;
		logic [63:0] bar;
		logic [63:0] src;
		logic [2:0] mode;
		n = (count_reg > MaxColumns) ? MaxColumns : int'(count_reg);
		r = '0;
		if (t.action == ACT_READ) begin
			r.entry_index = t.read_index;
			if (bucket_used[t.read_index]) begin
				r.status = ST_READ_OK;
				r.group_symbol = bucket_symbol[t.read_index];
				r.bar_start = bucket_bar[t.read_index];
				for (int c = 0; c < n; c++) begin
					case (c)
						0: r.value_zero = bucket_value[t.read_index][c];
						1: r.value_one = bucket_value[t.read_index][c];
						2: r.value_two = bucket_value[t.read_index][c];
						default: r.value_three = bucket_value[t.read_index][c];
					endcase
				end
			end else begin
				r.status = ST_READ_NO;
			end
			return r;
		end
		bar = '0;
		if (width_reg != 0)
			bar = ($signed(t.stamp) / $signed({1'b0, width_reg})) * $signed({1'b0, width_reg});
		found = 0;
		idx = 0;
		for (int i = 0; i < TableDepth && !found; i++) begin
			if (bucket_used[i] && bucket_symbol[i] == t.symbol && bucket_bar[i] == bar) begin
				found = 1;
				idx = i;
			end
		end
		r.group_symbol = t.symbol;
		r.bar_start = bar;
		if (found) begin
			r.status = ST_UPDATED;
		end else if (bucket_fill >= TableDepth) begin
			r.status = ST_FULL;
			return r;
		end else begin
			idx = bucket_fill;
			bucket_fill++;
			bucket_used[idx] = 1'b1;
			bucket_symbol[idx] = t.symbol;
			bucket_bar[idx] = bar;
			for (int c = 0; c < MaxColumns; c++) begin
				mode = modes_reg[3*c +: 3];
				bucket_value[idx][c] = (mode == MODE_MIN) ? SIGNED_TOP :
					(mode == MODE_MAX) ? SIGNED_BOTTOM : 64'd0;
			end
			r.status = ST_CREATED;
		end
		r.entry_index = idx[7:0];
		for (int c = 0; c < n; c++) begin
			case (sources_reg[2*c +: 2])
				SRC_PRICE:  src = t.price;
				SRC_VOLUME: src = t.volume;
				default:    src = '0;
			endcase
			case (modes_reg[3*c +: 3])
				MODE_SUM:   bucket_value[idx][c] += src;
				MODE_COUNT: bucket_value[idx][c] += 64'd1;
				MODE_MIN:   if ($signed(src) < $signed(bucket_value[idx][c])) bucket_value[idx][c] = src;
				MODE_MAX:   if ($signed(src) > $signed(bucket_value[idx][c])) bucket_value[idx][c] = src;
				MODE_FIRST: if (r.status == ST_CREATED) bucket_value[idx][c] = src;
				MODE_LAST:  bucket_value[idx][c] = src;
				default: ;
			endcase
			case (c)
				0: r.value_zero = bucket_value[idx][c];
				1: r.value_one = bucket_value[idx][c];
				2: r.value_two = bucket_value[idx][c];
				default: r.value_three = bucket_value[idx][c];
			endcase
		end
		return r;
	endfunction

	// Write one register, then leave the bus idle before returning
	task automatic write_reg(logic [1:0] reg_id, logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_id, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (reg_id)
			REG_BAR_WIDTH: width_reg = value[62:0];
			REG_COL_COUNT: count_reg = value[2:0];
			REG_COL_MODES: modes_reg = value[11:0];
			default:       sources_reg = value[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic set_columns(logic [62:0] width, logic [2:0] count, logic [11:0] modes,
			logic [7:0] sources);
		write_reg(REG_BAR_WIDTH, {1'b0, width});
		write_reg(REG_COL_COUNT, {61'd0, count});
		write_reg(REG_COL_MODES, {52'd0, modes});
		write_reg(REG_COL_SRCS, {56'd0, sources});
	endtask

	// Offer one transaction, optionally idling first; override typed fields
	task automatic send_tick(tick_t t, bit typed, logic [2:0] status, logic [7:0] index);
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= t.action;
		s_axis_tdata <= {8'd0, t.read_index, t.volume, t.price, t.stamp, t.symbol};
		do @(posedge clk); while (!s_axis_tready);
		r = fold_tick(t);
		if (typed) begin
			r.status = status;
			r.entry_index = index;
		end
		pending_results.insert(pending_results.size(), r);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly a few hot symbols near recent times, with full-range noise
	function automatic tick_t make_tick();
		tick_t t;
		t.action = ($urandom_range(99) < 20) ? ACT_READ : ACT_TICK;
		t.symbol = ($urandom_range(99) < 70) ? 32'($urandom_range(7)) - 32'd3 : $urandom;
		t.stamp = ($urandom_range(99) < 70) ? 64'($urandom_range(3000)) - 64'd1500 : rand64();
		t.price = ($urandom_range(99) < 50) ? 64'($urandom_range(2000)) - 64'd1000 : rand64();
		t.volume = ($urandom_range(99) < 50) ? 64'($urandom_range(500)) : rand64();
		t.read_index = ($urandom_range(99) < 60) ? 8'($urandom_range(15)) : 8'($urandom);
		return t;
	endfunction

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Check every result transaction against the oldest expectation
	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no expectation waiting");
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, m_axis_tuser);
				check_field("entry_index", want.entry_index, m_axis_tdata[7:0]);
				check_field("group_symbol", want.group_symbol, m_axis_tdata[39:8]);
				check_field("bar_start", want.bar_start, m_axis_tdata[103:40]);
				check_field("value_zero", want.value_zero, m_axis_tdata[167:104]);
				check_field("value_one", want.value_one, m_axis_tdata[231:168]);
				check_field("value_two", want.value_two, m_axis_tdata[295:232]);
				check_field("value_three", want.value_three, m_axis_tdata[359:296]);
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Hold a hard limit on the run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** group_by_bar_aggregator_unit: FAILED **");
			$finish;
		end
	end

	row_t rows[$];

	function automatic void add_row(row_t row);
		rows.insert(rows.size(), row);
	endfunction

	initial begin
		logic [62:0] widths [PHASES];
		logic [2:0] counts [PHASES];
		logic [11:0] modes [PHASES];
		logic [7:0] sources [PHASES];
		foreach (bucket_used[i]) bucket_used[i] = 1'b0;

		// Directed rows: typed status and index where obvious
		add_row('{'{ACT_READ, 32'd0, 64'd0, 64'd0, 64'd0, 8'd0}, 1, ST_READ_NO, 8'd0});
		add_row('{'{ACT_TICK, 32'd5, 64'd17, 64'd100, 64'd3, 8'd0}, 1, ST_CREATED, 8'd0});
		add_row('{'{ACT_TICK, 32'd5, 64'd19, 64'd40, 64'd9, 8'd0}, 1, ST_UPDATED, 8'd0});
		add_row('{'{ACT_TICK, 32'd5, 64'd20, 64'd7, 64'd1, 8'd0}, 1, ST_CREATED, 8'd1});
		add_row('{'{ACT_TICK, 32'h8000_0000, SIGNED_BOTTOM, SIGNED_TOP, SIGNED_BOTTOM, 8'd0},
			1, ST_CREATED, 8'd2});
		add_row('{'{ACT_TICK, 32'h7FFF_FFFF, SIGNED_TOP, SIGNED_BOTTOM, SIGNED_TOP, 8'hFF},
			1, ST_CREATED, 8'd3});
		add_row('{'{ACT_TICK, 32'd5, -64'sd1, -64'sd5, 64'd2, 8'd0}, 1, ST_CREATED, 8'd4});
		add_row('{'{ACT_TICK, 32'd5, -64'sd19, 64'd3, -64'sd2, 8'd0}, 1, ST_CREATED, 8'd5});
		add_row('{'{ACT_READ, 32'd0, 64'd0, 64'd0, 64'd0, 8'd0}, 1, ST_READ_OK, 8'd0});
		add_row('{'{ACT_READ, 32'hFFFF_FFFF, 64'd0, 64'd0, 64'd0, 8'hFF}, 1, ST_READ_NO, 8'hFF});
		add_row('{'{ACT_READ, 32'd0, 64'd0, 64'd0, 64'd0, 8'd2}, 1, ST_READ_OK, 8'd2});
		add_row('{'{ACT_TICK, 32'd5, 64'd11, SIGNED_TOP, SIGNED_TOP, 8'd0}, 0, 3'd0, 8'd0});
		add_row('{'{ACT_TICK, 32'd5, 64'd12, 64'd1, SIGNED_BOTTOM, 8'd0}, 0, 3'd0, 8'd0});
		add_row('{'{ACT_TICK, 32'h8000_0000, SIGNED_BOTTOM + 1, 64'd0, 64'd0, 8'd0},
			0, 3'd0, 8'd0});
		add_row('{'{ACT_READ, 32'd0, 64'd0, 64'd0, 64'd0, 8'd5}, 1, ST_READ_OK, 8'd5});

		// Phase register settings, extremes among them
		widths = '{63'd0, 63'd1, {63{1'b1}}, 63'd1000, 63'd0, 63'd7};
		counts = '{3'd4, 3'd7, 3'd0, 3'd5, 3'd2, 3'd3};
		modes = '{pack_modes(MODE_COUNT, MODE_LAST, MODE_MIN, MODE_MAX),
			pack_modes(MODE_SPARE6, MODE_SPARE7, MODE_SUM, MODE_LAST),
			12'hFFF, 12'd0, 12'd0,
			pack_modes(MODE_SUM, MODE_MIN, MODE_MAX, MODE_FIRST)};
		sources = '{pack_sources(SRC_PRICE, SRC_VOLUME, SRC_VOLUME, SRC_PRICE), 8'hFF, 8'd0, 8'd0,
			pack_sources(SRC_SPARE, SRC_PRICE, SRC_ZERO, SRC_VOLUME),
			pack_sources(SRC_PRICE, SRC_PRICE, SRC_VOLUME, SRC_VOLUME)};
		widths[4] = 63'($urandom) << $urandom_range(31);
		modes[3] = 12'($urandom);
		sources[3] = 8'($urandom);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_columns(63'd10, 3'd4, pack_modes(MODE_SUM, MODE_MIN, MODE_MAX, MODE_FIRST),
			pack_sources(SRC_PRICE, SRC_PRICE, SRC_VOLUME, SRC_VOLUME));
		foreach (rows[i]) send_tick(rows[i].item, rows[i].typed, rows[i].status, rows[i].index);
		s_axis_tvalid <= 1'b0;
		drain();

		// Random phases: receiver idles most first, then sender, then neither
		for (int p = 0; p < PHASES; p++) begin
			set_columns(widths[p], counts[p], modes[p], sources[p]);
			send_idle_pct = (p < 2) ? 16 : (p < 4) ? 60 : 0;
			recv_idle_pct = (p < 2) ? 60 : (p < 4) ? 16 : 0;
			for (int k = 0; k < PHASE_ITEMS; k++) send_tick(make_tick(), 0, 3'd0, 8'd0);
			s_axis_tvalid <= 1'b0;
			drain();
		end

		if (errors == 0) begin
			$display("** group_by_bar_aggregator_unit: PASSED **");
		end else begin
			$display("** group_by_bar_aggregator_unit: FAILED **");
		end
		$finish;
	end

endmodule
